[sv/sync_length_frame_deframer_top_defines.svh]
// Assertion macros shared by the deframer checker.
// Depends on signals named clk and rst_n in the scope of use.
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Clocked assertion, suspended while reset is asserted
`define SLFD_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define SLFD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/slfd_pkg.sv]
// Types and constants of the sync-word / length-prefixed frame deframer.
// No dependencies; used by the interfaces and the top level.
package slfd_pkg;

    localparam int unsigned POS_W     = 6;
    localparam int unsigned FILL_W    = 3;
    localparam int unsigned LEN_W     = 32;
    localparam int unsigned SYNC_W    = 32;
    localparam int unsigned BYTE_W    = 8;

    // Header offsets
    localparam logic [POS_W-1:0]  SYNC_BYTES = POS_W'(4);
    localparam logic [POS_W-1:0]  LEN_OFFSET = POS_W'(20);
    localparam logic [POS_W-1:0]  LEN_END    = POS_W'(24);
    localparam logic [FILL_W-1:0] WIN_FULL   = FILL_W'(4);

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [SYNC_W-1:0] sync_t;
    typedef logic [LEN_W-1:0]  len_t;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'b001,
        PH_HEADER = 3'b010,
        PH_BODY   = 3'b100
    } phase_t;

endpackage

[sv/slfd_rx_if.sv]
// Received byte stream channel: valid/ready with one byte of payload.
// Depends on slfd_pkg.
interface slfd_rx_if;
    logic            valid;
    logic            ready;
    slfd_pkg::byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[sv/slfd_frame_if.sv]
// Recovered frame byte channel: valid/ready with byte and frame markers.
// Depends on slfd_pkg.
interface slfd_frame_if;
    logic            valid;
    logic            ready;
    slfd_pkg::byte_t frame_byte;
    logic            is_header;
    logic            first_of_frame;
    logic            last_of_frame;
    logic            resynced;

    modport source (output valid, output frame_byte, output is_header,
                    output first_of_frame, output last_of_frame,
                    output resynced, input ready);
    modport sink   (input valid, input frame_byte, input is_header,
                    input first_of_frame, input last_of_frame,
                    input resynced, output ready);
endinterface

[sv/slfd_cfg_if.sv]
// Configuration write channel carrying the sync word register value.
// Depends on slfd_pkg.
interface slfd_cfg_if;
    logic            valid;
    logic            ready;
    slfd_pkg::sync_t sync_word;

    modport source (output valid, output sync_word, input ready);
    modport sink   (input valid, input sync_word, output ready);
endinterface

[sv/sync_length_frame_deframer_top.sv]
// Sync-word / length-prefixed frame deframer, top level.
// Depends on slfd_pkg, slfd_rx_if, slfd_frame_if and slfd_cfg_if.
//
// Usage:
//   rx    : received bytes, one transfer per byte.
//   frame : header bytes from offset 4 on, then body bytes, each with
//           is_header, first_of_frame, last_of_frame and resynced marks.
//           The four sync word bytes produce no output transfer.
//   cfg   : writes the 32-bit sync word; always ready. Write it while idle.
// The block hunts over a four-byte sliding window until it matches the
// sync word, then passes the header (body length big-endian at offset 20)
// and that many body bytes. After the last byte it hunts again; bytes
// pushed out of a full window mark the next frame as resynced.
// A byte accepted on rx is registered and offered on frame in the cycle after.
// Throughput: one byte per cycle, set by the single result register;
// rx.ready follows frame.ready when that register holds an untaken byte.
// Reset: hunting, empty window, sync word zero, no output pending.
// A stall on frame holds the result register and drops rx.ready in the
// same cycle; no further byte is taken until the held result is taken.
module sync_length_frame_deframer_top #(
    parameter int unsigned HEADER_BYTES = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    slfd_rx_if.sink            rx,
    slfd_frame_if.source       frame,
    slfd_cfg_if.sink           cfg
);

    localparam int unsigned PW = slfd_pkg::POS_W;
    localparam logic [PW-1:0] HDR_LAST = PW'(HEADER_BYTES - 1);

    slfd_pkg::phase_t             phase_reg, phase_next;
    slfd_pkg::sync_t              window_reg, window_next;
    logic [slfd_pkg::FILL_W-1:0]  fill_reg, fill_next;
    logic [PW-1:0]                pos_reg, pos_next;
    slfd_pkg::len_t               accum_reg, accum_next;
    slfd_pkg::len_t               remain_reg, remain_next;
    logic                         discard_reg, discard_next;
    slfd_pkg::sync_t              sync_word_reg;

    logic                         out_valid_reg, out_valid_next;
    slfd_pkg::byte_t              out_byte_reg;
    logic                         out_hdr_reg, out_first_reg;
    logic                         out_last_reg, out_resync_reg;

    logic                         in_xfer;
    logic                         emit;
    logic                         emit_hdr, emit_first, emit_last;
    slfd_pkg::sync_t              shifted;
    slfd_pkg::len_t               accum_upd;
    slfd_pkg::len_t               remain_dec;

    // Accept a byte whenever the result register is free or being drained
    assign rx.ready  = !out_valid_reg || frame.ready;
    assign in_xfer   = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    assign shifted    = {window_reg[slfd_pkg::SYNC_W-9:0], rx.rx_byte};
    assign remain_dec = remain_reg - slfd_pkg::LEN_W'(1);
    assign accum_upd  = (pos_reg >= slfd_pkg::LEN_OFFSET && pos_reg < slfd_pkg::LEN_END)
                        ? {accum_reg[slfd_pkg::LEN_W-9:0], rx.rx_byte} : accum_reg;

    // Next-state logic for one accepted byte
    always_comb
    begin
        phase_next   = phase_reg;
        window_next  = window_reg;
        fill_next    = fill_reg;
        pos_next     = pos_reg;
        accum_next   = accum_reg;
        remain_next  = remain_reg;
        discard_next = discard_reg;
        emit         = 1'b0;
        emit_hdr     = 1'b0;
        emit_first   = 1'b0;
        emit_last    = 1'b0;
        case (phase_reg)
            slfd_pkg::PH_HEADER:
            begin
                emit       = 1'b1;
                emit_hdr   = 1'b1;
                emit_first = (pos_reg == slfd_pkg::SYNC_BYTES);
                accum_next = accum_upd;
                if (pos_reg >= HDR_LAST)
                begin
                    if (accum_upd == '0)
                    begin
                        // empty body: header end closes the frame
                        emit_last    = 1'b1;
                        phase_next   = slfd_pkg::PH_HUNT;
                        window_next  = '0;
                        fill_next    = '0;
                        pos_next     = '0;
                        discard_next = 1'b0;
                    end
                    else
                    begin
                        remain_next = accum_upd;
                        phase_next  = slfd_pkg::PH_BODY;
                        pos_next    = '0;
                    end
                end
                else
                begin
                    pos_next = pos_reg + PW'(1);
                end
            end
            slfd_pkg::PH_BODY:
            begin
                emit        = 1'b1;
                remain_next = remain_dec;
                if (remain_dec == '0)
                begin
                    emit_last    = 1'b1;
                    phase_next   = slfd_pkg::PH_HUNT;
                    window_next  = '0;
                    fill_next    = '0;
                    pos_next     = '0;
                    discard_next = 1'b0;
                end
            end
            default:
            begin
                // hunt: slide the window, drop the oldest byte once full
                window_next = shifted;
                if (fill_reg >= slfd_pkg::WIN_FULL)
                    discard_next = 1'b1;
                else
                    fill_next = fill_reg + slfd_pkg::FILL_W'(1);
                if ((fill_reg >= slfd_pkg::WIN_FULL - slfd_pkg::FILL_W'(1))
                    && shifted == sync_word_reg)
                begin
                    phase_next  = slfd_pkg::PH_HEADER;
                    pos_next    = slfd_pkg::SYNC_BYTES;
                    accum_next  = '0;
                    remain_next = '0;
                end
            end
        endcase
    end

    // Result register valid: load on an emitting transfer, clear when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_xfer)
            out_valid_next = emit;
        else if (frame.ready)
            out_valid_next = 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= slfd_pkg::PH_HUNT;
            window_reg    <= '0;
            fill_reg      <= '0;
            pos_reg       <= '0;
            accum_reg     <= '0;
            remain_reg    <= '0;
            discard_reg   <= 1'b0;
            sync_word_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                phase_reg   <= phase_next;
                window_reg  <= window_next;
                fill_reg    <= fill_next;
                pos_reg     <= pos_next;
                accum_reg   <= accum_next;
                remain_reg  <= remain_next;
                discard_reg <= discard_next;
            end
            if (cfg.valid && cfg.ready)
                sync_word_reg <= cfg.sync_word;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer && emit)
        begin
            out_byte_reg   <= rx.rx_byte;
            out_hdr_reg    <= emit_hdr;
            out_first_reg  <= emit_first;
            out_last_reg   <= emit_last;
            out_resync_reg <= discard_reg;
        end
    end

    assign frame.valid          = out_valid_reg;
    assign frame.frame_byte     = out_byte_reg;
    assign frame.is_header      = out_hdr_reg;
    assign frame.first_of_frame = out_first_reg;
    assign frame.last_of_frame  = out_last_reg;
    assign frame.resynced       = out_resync_reg;

endmodule

[sv/slfd_checker.sv]
// Port-level checks for the deframer top level, plus its bind.
// Depends on slfd_pkg and sync_length_frame_deframer_top_defines.svh.
`include "sync_length_frame_deframer_top_defines.svh"

module slfd_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            rx_valid,
    input logic            rx_ready,
    input logic            fr_valid,
    input logic            fr_ready,
    input slfd_pkg::byte_t fr_byte,
    input logic            fr_hdr,
    input logic            fr_first,
    input logic            fr_last,
    input logic            fr_resync
);

    // Hold a stalled result
    `SLFD_ASSERT_CLK(a_valid_hold, fr_valid && !fr_ready |=> fr_valid, "frame valid dropped while stalled")
    `SLFD_ASSERT_CLK(a_payload_hold, fr_valid && !fr_ready |=> $stable({fr_byte, fr_hdr, fr_first, fr_last, fr_resync}), "frame payload changed while stalled")

    // A new result only follows a byte transfer in the previous cycle
    `SLFD_ASSERT_CLK(a_out_from_in, $rose(fr_valid) |-> $past(rx_valid && rx_ready), "frame output without a prior rx transfer")

    // Nothing is offered while reset is held
    `SLFD_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !fr_valid, "frame valid during reset")

endmodule

bind sync_length_frame_deframer_top slfd_checker u_slfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_valid  (rx.valid),
    .rx_ready  (rx.ready),
    .fr_valid  (frame.valid),
    .fr_ready  (frame.ready),
    .fr_byte   (frame.frame_byte),
    .fr_hdr    (frame.is_header),
    .fr_first  (frame.first_of_frame),
    .fr_last   (frame.last_of_frame),
    .fr_resync (frame.resynced)
);

[tb/testbench.sv]
// Self-checking testbench for the sync-word / length-prefixed frame deframer.
// Depends on slfd_pkg, slfd_rx_if, slfd_frame_if, slfd_cfg_if and
// sync_length_frame_deframer_top; compares every frame transfer with an internal predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HDR_BYTES   = 24;
    localparam int unsigned CLK_PERIOD  = 20;
    localparam int unsigned RESET_CYCLES = 10;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASE_ITEMS = 235;
    localparam int unsigned NUM_PHASES  = 8;
    localparam int unsigned DIRECTED_ROWS = 27;

    // One recovered byte with its frame markers
    typedef struct packed {
        slfd_pkg::byte_t data;
        logic            hdr;
        logic            sof;
        logic            eof;
        logic            resync;
    } frame_beat_t;

    typedef enum logic [1:0] {
        ROW_SYNC_WRITE,
        ROW_BYTE,
        ROW_BYTE_EXACT,
        ROW_BYTE_SILENT
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [31:0] value;
        frame_beat_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    slfd_rx_if    rx_if();
    slfd_frame_if frame_if();
    slfd_cfg_if   cfg_if();

    sync_length_frame_deframer_top #(
        .HEADER_BYTES (HDR_BYTES)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .frame (frame_if),
        .cfg   (cfg_if)
    );

    // Predictor state
    slfd_pkg::sync_t  cur_sync;
    slfd_pkg::phase_t deframe_phase;
    slfd_pkg::sync_t  sync_win;
    int unsigned      win_fill;
    int unsigned      hdr_pos;
    slfd_pkg::len_t   len_acc;
    slfd_pkg::len_t   body_left;
    logic             dropped;

    frame_beat_t     expected_beats[$];
    slfd_pkg::byte_t burst[$];
    stim_row_t       directed_rows [0:DIRECTED_ROWS-1];

    int unsigned rx_calm;
    int unsigned fr_calm;
    int unsigned mismatch_count;
    int unsigned bytes_sent;
    int unsigned beats_seen;
    int unsigned frames_closed;
    int unsigned resync_frames;
    int unsigned sync_settings;
    int unsigned cycle_count;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Return to hunting with an empty window
    function automatic void rearm_hunt();
        deframe_phase = slfd_pkg::PH_HUNT;
        sync_win      = '0;
        win_fill      = 0;
        hdr_pos       = 0;
        dropped       = 1'b0;
    endfunction

    // Advance the predictor by one stream byte; return 1 when a beat comes out
    function automatic bit deframe_byte(input slfd_pkg::byte_t b, output frame_beat_t beat);
        int unsigned pos;
        beat        = '0;
        beat.data   = b;
        beat.resync = dropped;
        case (deframe_phase)
            slfd_pkg::PH_HEADER: begin
                pos      = hdr_pos;
                beat.hdr = 1'b1;
                beat.sof = (pos == slfd_pkg::SYNC_BYTES);
                if (pos >= slfd_pkg::LEN_OFFSET && pos < slfd_pkg::LEN_END)
                    len_acc = {len_acc[23:0], b};
                if (pos + 1 >= HDR_BYTES) begin
                    if (len_acc == '0) begin
                        beat.eof = 1'b1;
                        rearm_hunt();
                    end
                    else begin
                        body_left     = len_acc;
                        deframe_phase = slfd_pkg::PH_BODY;
                        hdr_pos       = 0;
                    end
                end
                else begin
                    hdr_pos = (pos + 1) & 32'h3F;
                end
                return 1'b1;
            end
            slfd_pkg::PH_BODY: begin
                body_left = body_left - 1;
                if (body_left == '0) begin
                    beat.eof = 1'b1;
                    rearm_hunt();
                end
                return 1'b1;
            end
            default: begin
                // Slide the window; a byte pushed out of a full window is lost
                if (win_fill >= slfd_pkg::WIN_FULL)
                    dropped = 1'b1;
                else
                    win_fill++;
                sync_win = {sync_win[23:0], b};
                if (win_fill >= slfd_pkg::WIN_FULL && sync_win == cur_sync) begin
                    deframe_phase = slfd_pkg::PH_HEADER;
                    hdr_pos       = 32'(slfd_pkg::SYNC_BYTES);
                    len_acc       = '0;
                    body_left     = '0;
                end
                return 1'b0;
            end
        endcase
    endfunction

    // Idle draw: calm stretches with no idling, otherwise a random idle gap
    function automatic int unsigned draw_gap(inout int unsigned calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
            calm = $urandom_range(16, 96);
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic slfd_pkg::len_t pick_body_len();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r <= 3)
            return '0;
        else if (r <= 15)
            return slfd_pkg::len_t'($urandom_range(1, 24));
        else if (r <= 18)
            return slfd_pkg::len_t'($urandom_range(25, 120));
        return slfd_pkg::len_t'($urandom_range(121, 300));
    endfunction

    function automatic void add_noise(input int unsigned n);
        for (int i = 0; i < n; i++)
            burst.push_back(slfd_pkg::byte_t'($urandom_range(0, 255)));
    endfunction

    // Append sync word, the first hdr_cnt header bytes after it and, if whole, the body
    function automatic void add_frame(input slfd_pkg::sync_t word, input slfd_pkg::len_t n,
                                      input int unsigned hdr_cnt);
        for (int i = 0; i < 4; i++)
            burst.push_back(word[31 - 8 * i -: 8]);
        for (int i = 0; i < hdr_cnt; i++) begin
            if (i + slfd_pkg::SYNC_BYTES >= slfd_pkg::LEN_OFFSET)
                burst.push_back(n[31 - 8 * (i + slfd_pkg::SYNC_BYTES - slfd_pkg::LEN_OFFSET) -: 8]);
            else
                burst.push_back(slfd_pkg::byte_t'($urandom_range(0, 255)));
        end
        if (hdr_cnt == HDR_BYTES - slfd_pkg::SYNC_BYTES)
            add_noise(n);
    endfunction

    // Offer one byte on rx and return at the edge that accepts it
    task automatic push_rx(input slfd_pkg::byte_t b);
        int unsigned gap;
        gap = draw_gap(rx_calm);
        @(negedge clk);
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic feed_byte(input slfd_pkg::byte_t b);
        frame_beat_t beat;
        push_rx(b);
        if (deframe_byte(b, beat))
            expected_beats.push_back(beat);
    endtask

    // Hold the sender until every expected beat is out and the block is quiet
    task automatic settle_idle();
        @(negedge clk);
        rx_if.valid <= 1'b0;
        while (expected_beats.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_sync(input slfd_pkg::sync_t word);
        @(negedge clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.sync_word <= word;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cur_sync = word;
        sync_settings++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endtask

    // Compare one frame transfer with the oldest expectation
    task automatic check_beat(input frame_beat_t got);
        frame_beat_t want;
        beats_seen++;
        if (expected_beats.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected frame transfer, expected none, actual %0h",
                     $time, got);
            return;
        end
        want = expected_beats.pop_front();
        if (got.data !== want.data)     report("frame_byte", want.data, got.data);
        if (got.hdr !== want.hdr)       report("is_header", want.hdr, got.hdr);
        if (got.sof !== want.sof)       report("first_of_frame", want.sof, got.sof);
        if (got.eof !== want.eof)       report("last_of_frame", want.eof, got.eof);
        if (got.resync !== want.resync) report("resynced", want.resync, got.resync);
        if (want.eof) begin
            frames_closed++;
            if (want.resync)
                resync_frames++;
        end
    endtask

    // One sync word setting: mostly well-formed frames, some noise and broken pieces
    task automatic run_sync_phase(input slfd_pkg::sync_t word, input int unsigned budget);
        int unsigned sent;
        int unsigned pick;
        int unsigned k;
        settle_idle();
        write_sync(word);
        sent = 0;
        while (sent < budget) begin
            burst = {};
            pick  = $urandom_range(0, 9);
            if (pick <= 6) begin
                if ($urandom_range(0, 3) == 0)
                    add_noise($urandom_range(1, 6));
                add_frame(word, pick_body_len(), HDR_BYTES - slfd_pkg::SYNC_BYTES);
            end
            else if (pick == 7) begin
                // partial sync word, left in the window for what follows
                k = $urandom_range(1, 3);
                for (int i = 0; i < k; i++)
                    burst.push_back(word[31 - 8 * i -: 8]);
            end
            else if (pick == 8) begin
                add_frame(word, pick_body_len(), $urandom_range(0, 18));
            end
            else begin
                add_noise($urandom_range(1, 10));
            end
            foreach (burst[i])
                feed_byte(burst[i]);
            sent += burst.size();
        end
    endtask

    // Result side: random stalls, check each transfer
    initial begin : frame_sink
        int unsigned gap;
        frame_beat_t got;
        frame_if.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            gap = draw_gap(fr_calm);
            @(negedge clk);
            if (gap > 0) begin
                frame_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            frame_if.ready <= 1'b1;
            @(posedge clk);
            while (!frame_if.valid)
                @(posedge clk);
            got = {frame_if.frame_byte, frame_if.is_header, frame_if.first_of_frame,
                   frame_if.last_of_frame, frame_if.resynced};
            check_beat(got);
        end
    end

    // Run-length guard
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d beats still expected",
                 cycle_count, expected_beats.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        slfd_pkg::sync_t plan [0:NUM_PHASES-1];
        frame_beat_t     beat;
        bit              produced;
        int unsigned     k;

        rst_n            <= 1'b0;
        rx_if.valid      <= 1'b0;
        rx_if.rx_byte    <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.sync_word <= '0;
        cur_sync       = '0;
        rearm_hunt();
        len_acc        = '0;
        body_left      = '0;
        rx_calm        = 0;
        fr_calm        = 0;
        mismatch_count = 0;
        bytes_sent     = 0;
        beats_seen     = 0;
        frames_closed  = 0;
        resync_frames  = 0;
        sync_settings  = 0;

        // Junk before the first sync word, one-byte body, extreme byte values
        directed_rows = '{
            '{ROW_SYNC_WRITE,  32'h0000_0000, '0},
            '{ROW_BYTE_SILENT, 32'h0000_00FF, '0},
            '{ROW_BYTE_SILENT, 32'h0000_0000, '0},
            '{ROW_BYTE_SILENT, 32'h0000_0000, '0},
            '{ROW_BYTE_SILENT, 32'h0000_0000, '0},
            '{ROW_BYTE_SILENT, 32'h0000_0000, '0},
            '{ROW_BYTE_EXACT,  32'h0000_00FF, '{8'hFF, 1'b1, 1'b1, 1'b0, 1'b1}},
            '{ROW_BYTE,        32'h0000_0000, '0},
            '{ROW_BYTE,        32'h0000_0080, '0},
            '{ROW_BYTE,        32'h0000_0001, '0},
            '{ROW_BYTE,        32'h0000_007F, '0},
            '{ROW_BYTE,        32'h0000_00FE, '0},
            '{ROW_BYTE,        32'h0000_0055, '0},
            '{ROW_BYTE,        32'h0000_00AA, '0},
            '{ROW_BYTE,        32'h0000_0002, '0},
            '{ROW_BYTE,        32'h0000_0004, '0},
            '{ROW_BYTE,        32'h0000_0008, '0},
            '{ROW_BYTE,        32'h0000_0010, '0},
            '{ROW_BYTE,        32'h0000_0020, '0},
            '{ROW_BYTE,        32'h0000_0040, '0},
            '{ROW_BYTE,        32'h0000_00C3, '0},
            '{ROW_BYTE,        32'h0000_003C, '0},
            '{ROW_BYTE,        32'h0000_0000, '0},
            '{ROW_BYTE,        32'h0000_0000, '0},
            '{ROW_BYTE,        32'h0000_0000, '0},
            '{ROW_BYTE_EXACT,  32'h0000_0001, '{8'h01, 1'b1, 1'b0, 1'b0, 1'b1}},
            '{ROW_BYTE_EXACT,  32'h0000_00A5, '{8'hA5, 1'b0, 1'b0, 1'b1, 1'b1}}
        };

        plan[0] = 32'hFFFF_FFFF;
        plan[1] = 32'h0000_0000;
        plan[2] = slfd_pkg::sync_t'($urandom());
        plan[3] = 32'h1ACF_FC1D;
        plan[4] = slfd_pkg::sync_t'($urandom());
        plan[5] = 32'h8000_0001;
        plan[6] = slfd_pkg::sync_t'($urandom());
        plan[7] = 32'hFFFF_FFFF;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_SYNC_WRITE) begin
                settle_idle();
                write_sync(directed_rows[i].value);
            end
            else begin
                push_rx(directed_rows[i].value[7:0]);
                produced = deframe_byte(directed_rows[i].value[7:0], beat);
                if (directed_rows[i].kind == ROW_BYTE_EXACT)
                    expected_beats.push_back(directed_rows[i].want);
                else if (directed_rows[i].kind == ROW_BYTE && produced)
                    expected_beats.push_back(beat);
            end
        end

        // Random frames under each sync word; a phase may end mid-frame
        for (int p = 0; p < NUM_PHASES; p++)
            run_sync_phase(plan[p], PHASE_ITEMS);

        // Largest body length: follow part of a body that never ends
        settle_idle();
        write_sync(slfd_pkg::sync_t'($urandom()));
        burst = {};
        add_noise(3);
        add_frame(cur_sync, 32'hFFFF_FFFF, HDR_BYTES - slfd_pkg::SYNC_BYTES - 4);
        for (int i = 0; i < 4; i++)
            burst.push_back(8'hFF);
        add_noise(40);
        foreach (burst[i])
            feed_byte(burst[i]);

        // Drain
        @(negedge clk);
        rx_if.valid <= 1'b0;
        k = 0;
        while (expected_beats.size() > 0 && k < 5000) begin
            @(posedge clk);
            k++;
        end
        repeat (8) @(posedge clk);
        if (expected_beats.size() > 0) begin
            mismatch_count++;
            $display("%0t: %0d expected beats never arrived, expected %0h, actual none",
                     $time, expected_beats.size(), expected_beats[0]);
        end

        $display("Sent %0d stream bytes under %0d sync words; checked %0d frame bytes",
                 bytes_sent, sync_settings, beats_seen);
        $display("Frames closed: %0d, of them resynced: %0d, mismatches: %0d",
                 frames_closed, resync_frames, mismatch_count);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sync_length_frame_deframer_top.f]
+incdir+sv
sv/slfd_pkg.sv
sv/slfd_rx_if.sv
sv/slfd_frame_if.sv
sv/slfd_cfg_if.sv
sv/sync_length_frame_deframer_top.sv
sv/slfd_checker.sv
tb/testbench.sv
